[rtl/lsac_pkg.sv]
// Shared types and constants for the LRU set-associative cache model.
// Used by lsac_front, lsac_queue, lsac_back and the top level; no dependencies.
package lsac_pkg;

    localparam int MAX_SET_BITS = 4;
    localparam int MAX_WAYS     = 4;
    localparam int NUM_SETS     = 1 << MAX_SET_BITS;
    localparam int SET_W        = MAX_SET_BITS;
    localparam int WAY_W        = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
    localparam int NW_W         = $clog2(MAX_WAYS + 1);

    localparam int ADDR_W  = 32;
    localparam int TAG_W   = 30;
    localparam int STAMP_W = 64;
    localparam int AGE_W   = 32;
    localparam int TOTAL_W = 32;

    localparam int SB_W       = 3;
    localparam int BB_W       = 5;
    localparam int WAYS_W     = 3;
    localparam int CFG_DATA_W = 5;
    localparam int CFG_IDX_W  = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_SET_BITS   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_BITS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WAYS       = 2'd2;

    localparam logic [SB_W-1:0]   RST_SET_BITS   = 3'd1;
    localparam logic [BB_W-1:0]   RST_BLOCK_BITS = 5'd4;
    localparam logic [WAYS_W-1:0] RST_WAYS       = 3'd1;

    localparam int QUEUE_DEPTH = 2;
    localparam int Q_PTR_W     = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int Q_CNT_W     = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [1:0] {
        OP_LOAD   = 2'd0,
        OP_STORE  = 2'd1,
        OP_MODIFY = 2'd2,
        OP_OTHER  = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        B_IDLE,
        B_EVAL,
        B_COMMIT
    } t_bstate;

    typedef struct packed {
        logic             access;
        logic             modify;
        logic [SET_W-1:0] set_idx;
        logic [TAG_W-1:0] tag;
        logic [NW_W-1:0]  nw;
    } t_job;

    typedef struct packed {
        logic [1:0]         hits;
        logic [1:0]         misses;
        logic               evictions;
        logic [TOTAL_W-1:0] total_hits;
        logic [TOTAL_W-1:0] total_misses;
        logic [TOTAL_W-1:0] total_evictions;
    } t_result;

endpackage

[rtl/lsac_front.sv]
// Front end: configuration registers and decode of one trace item into set, tag and access kind.
// Depends on lsac_pkg.
module lsac_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [lsac_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [lsac_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  lsac_pkg::t_op                 i_op,
    input  logic [lsac_pkg::ADDR_W-1:0]   i_address,
    output lsac_pkg::t_job                o_job
);
    import lsac_pkg::*;

    logic [SB_W-1:0]   r_set_bits;
    logic [BB_W-1:0]   r_block_bits;
    logic [WAYS_W-1:0] r_ways;

    logic [SB_W-1:0]   eff_sb;
    logic [BB_W-1:0]   eff_bb;
    logic [NW_W-1:0]   eff_nw;
    logic [SET_W-1:0]  set_mask;
    logic [ADDR_W-1:0] shifted;
    logic [BB_W:0]     tag_shift;
    logic [ADDR_W-1:0] tag_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_set_bits   <= RST_SET_BITS;
            r_block_bits <= RST_BLOCK_BITS;
            r_ways       <= RST_WAYS;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_SET_BITS:   r_set_bits   <= i_cfg_data[SB_W-1:0];
                CFG_BLOCK_BITS: r_block_bits <= i_cfg_data[BB_W-1:0];
                CFG_WAYS:       r_ways       <= i_cfg_data[WAYS_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        if (r_set_bits == '0) begin
            eff_sb = SB_W'(1);
        end else if (32'(r_set_bits) > MAX_SET_BITS) begin
            eff_sb = SB_W'(MAX_SET_BITS);
        end else begin
            eff_sb = r_set_bits;
        end

        eff_bb = (r_block_bits == '0) ? BB_W'(1) : r_block_bits;

        if (r_ways == '0) begin
            eff_nw = NW_W'(1);
        end else if (32'(r_ways) > MAX_WAYS) begin
            eff_nw = NW_W'(MAX_WAYS);
        end else begin
            eff_nw = NW_W'(r_ways);
        end

        shifted   = i_address >> eff_bb;
        set_mask  = ~({SET_W{1'b1}} << eff_sb);
        tag_shift = {1'b0, eff_bb} + (BB_W+1)'(eff_sb);
        tag_full  = (tag_shift >= (BB_W+1)'(ADDR_W)) ? '0 : (i_address >> tag_shift);

        o_job.access  = (i_op != OP_OTHER);
        o_job.modify  = (i_op == OP_MODIFY);
        o_job.set_idx = shifted[SET_W-1:0] & set_mask;
        o_job.tag     = tag_full[TAG_W-1:0];
        o_job.nw      = eff_nw;
    end

endmodule

[rtl/lsac_queue.sv]
// Short job queue between the decode front end and the tag store back end.
// Depends on lsac_pkg.
module lsac_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  lsac_pkg::t_job i_push_job,
    output logic           o_push_ready,
    input  logic           i_pop,
    output logic           o_pop_valid,
    output lsac_pkg::t_job o_pop_job
);
    import lsac_pkg::*;

    t_job               r_entry [QUEUE_DEPTH];
    logic [Q_PTR_W-1:0] r_wr_ptr;
    logic [Q_PTR_W-1:0] r_rd_ptr;
    logic [Q_CNT_W-1:0] r_count;

    logic push_ok;
    logic pop_ok;

    assign o_push_ready = (r_count != Q_CNT_W'(QUEUE_DEPTH));
    assign o_pop_valid  = (r_count != '0);
    assign o_pop_job    = r_entry[r_rd_ptr];
    assign push_ok      = i_push && o_push_ready;
    assign pop_ok       = i_pop && o_pop_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push_ok) begin
                r_wr_ptr <= (r_wr_ptr == Q_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (pop_ok) begin
                r_rd_ptr <= (r_rd_ptr == Q_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (push_ok && !pop_ok) begin
                r_count <= r_count + 1'b1;
            end else if (pop_ok && !push_ok) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push_ok) begin
            r_entry[r_wr_ptr] <= i_push_job;
        end
    end

endmodule

[rtl/lsac_back.sv]
// Back end: per-set tag/stamp memory, valid bits, LRU lookup and update, totals, result register.
// Depends on lsac_pkg.
module lsac_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_job_valid,
    input  lsac_pkg::t_job    i_job,
    output logic              o_pop,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output lsac_pkg::t_result o_result
);
    import lsac_pkg::*;

    typedef logic [MAX_WAYS-1:0][TAG_W-1:0]   t_tag_row;
    typedef logic [MAX_WAYS-1:0][STAMP_W-1:0] t_stamp_row;

    t_bstate r_state;
    t_bstate n_state;
    logic    commit;

    t_tag_row            r_tag_mem   [NUM_SETS];
    t_stamp_row          r_stamp_mem [NUM_SETS];
    logic [MAX_WAYS-1:0] r_valid     [NUM_SETS];

    t_job               r_job;
    t_tag_row           r_tag_row;
    t_stamp_row         r_stamp_row;
    logic [STAMP_W-1:0] r_now;

    logic [MAX_WAYS-1:0] r_hit_vec;
    logic [MAX_WAYS-1:0] r_inv_vec;
    logic [MAX_WAYS-1:0] r_inuse_vec;
    logic [AGE_W-1:0]    r_age [MAX_WAYS];

    logic [TOTAL_W-1:0] r_hit_total;
    logic [TOTAL_W-1:0] r_miss_total;
    logic [TOTAL_W-1:0] r_evict_total;
    logic               r_out_valid;
    t_result            r_result;

    logic [MAX_WAYS-1:0] e_hit;
    logic [MAX_WAYS-1:0] e_inv;
    logic [MAX_WAYS-1:0] e_inuse;
    logic [STAMP_W-1:0]  e_diff [MAX_WAYS];
    logic [AGE_W-1:0]    e_age  [MAX_WAYS];

    logic               hit_any;
    logic               inv_any;
    logic [WAY_W-1:0]   hit_way;
    logic [WAY_W-1:0]   inv_way;
    logic [WAY_W-1:0]   victim;
    logic [AGE_W-1:0]   oldest;
    logic [WAY_W-1:0]   sel_way;
    t_tag_row           n_tag_row;
    t_stamp_row         n_stamp_row;
    logic [1:0]         n_hits;
    logic [1:0]         n_misses;
    logic               n_evict;
    logic [TOTAL_W-1:0] n_hit_total;
    logic [TOTAL_W-1:0] n_miss_total;
    logic [TOTAL_W-1:0] n_evict_total;

    function automatic logic [TOTAL_W-1:0] sat_add(input logic [TOTAL_W-1:0] a,
                                                   input logic [1:0] b);
        logic [TOTAL_W:0] s;
        s = {1'b0, a} + (TOTAL_W+1)'(b);
        return s[TOTAL_W] ? '1 : s[TOTAL_W-1:0];
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= B_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_pop   = 1'b0;
        commit  = 1'b0;
        unique case (r_state)
            B_IDLE: begin
                if (i_job_valid) begin
                    o_pop   = 1'b1;
                    n_state = B_EVAL;
                end
            end
            B_EVAL: begin
                n_state = B_COMMIT;
            end
            B_COMMIT: begin
                if (!r_out_valid || i_out_ready) begin
                    commit  = 1'b1;
                    n_state = B_IDLE;
                end
            end
            default: n_state = B_IDLE;
        endcase
    end

    // set row memory: read on pop, write back on commit of an access
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_job       <= i_job;
            r_tag_row   <= r_tag_mem[i_job.set_idx];
            r_stamp_row <= r_stamp_mem[i_job.set_idx];
        end
        if (commit && r_job.access) begin
            r_tag_mem[r_job.set_idx]   <= n_tag_row;
            r_stamp_mem[r_job.set_idx] <= n_stamp_row;
        end
    end

    always_comb begin
        for (int w = 0; w < MAX_WAYS; w++) begin
            e_inuse[w] = (NW_W'(w) < r_job.nw);
            e_hit[w]   = e_inuse[w] && r_valid[r_job.set_idx][w]
                         && (r_tag_row[w] == r_job.tag);
            e_inv[w]   = e_inuse[w] && !r_valid[r_job.set_idx][w];
            e_diff[w]  = r_now - r_stamp_row[w];
            e_age[w]   = (e_diff[w][STAMP_W-1:AGE_W] != '0) ? '1 : e_diff[w][AGE_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == B_EVAL) begin
            r_hit_vec   <= e_hit;
            r_inv_vec   <= e_inv;
            r_inuse_vec <= e_inuse;
            for (int w = 0; w < MAX_WAYS; w++) begin
                r_age[w] <= e_age[w];
            end
        end
    end

    always_comb begin
        hit_any = |r_hit_vec;
        inv_any = |r_inv_vec;
        hit_way = '0;
        inv_way = '0;
        for (int w = MAX_WAYS - 1; w >= 0; w--) begin
            if (r_hit_vec[w]) begin
                hit_way = WAY_W'(w);
            end
            if (r_inv_vec[w]) begin
                inv_way = WAY_W'(w);
            end
        end
        victim = '0;
        oldest = r_age[0];
        for (int w = 1; w < MAX_WAYS; w++) begin
            if (r_inuse_vec[w] && (r_age[w] > oldest)) begin
                oldest = r_age[w];
                victim = WAY_W'(w);
            end
        end

        if (hit_any) begin
            sel_way = hit_way;
        end else if (inv_any) begin
            sel_way = inv_way;
        end else begin
            sel_way = victim;
        end

        n_tag_row            = r_tag_row;
        n_tag_row[sel_way]   = r_job.tag;
        n_stamp_row          = r_stamp_row;
        n_stamp_row[sel_way] = r_now;

        n_hits   = r_job.access ? ({1'b0, hit_any} + {1'b0, r_job.modify}) : 2'd0;
        n_misses = {1'b0, r_job.access && !hit_any};
        n_evict  = r_job.access && !hit_any && !inv_any;

        n_hit_total   = sat_add(r_hit_total, n_hits);
        n_miss_total  = sat_add(r_miss_total, n_misses);
        n_evict_total = sat_add(r_evict_total, {1'b0, n_evict});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < NUM_SETS; s++) begin
                r_valid[s] <= '0;
            end
            r_now         <= '0;
            r_hit_total   <= '0;
            r_miss_total  <= '0;
            r_evict_total <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            if (commit) begin
                if (r_job.access) begin
                    r_valid[r_job.set_idx][sel_way] <= 1'b1;
                end
                r_now         <= r_now + 1'b1;
                r_hit_total   <= n_hit_total;
                r_miss_total  <= n_miss_total;
                r_evict_total <= n_evict_total;
                r_out_valid   <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (commit) begin
            r_result.hits            <= n_hits;
            r_result.misses          <= n_misses;
            r_result.evictions       <= n_evict;
            r_result.total_hits      <= n_hit_total;
            r_result.total_misses    <= n_miss_total;
            r_result.total_evictions <= n_evict_total;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_result    = r_result;

endmodule

[rtl/lru_set_associative_cache_sim.sv]
// Top level of the LRU set-associative cache tag store model.
// Instantiates lsac_front, lsac_queue and lsac_back; depends on lsac_pkg.
// Usage:
//   Input channel (i_in_valid/o_in_ready) takes one trace item: i_op and i_address.
//   Output channel (o_out_valid/i_out_ready) returns exactly one result per item:
//   per-item hit, miss and eviction counts and saturating running totals.
//   The config port (i_cfg_we, i_cfg_idx, i_cfg_data) writes set_bits (0),
//   block_bits (1) and ways (2); write only while the block is idle.
// Timing:
//   The front decodes the item and pushes it into a two-entry queue in the accept
//   cycle. The back end takes one item at a time: it reads the set row from the
//   tag/stamp memory, evaluates hit, free way and LRU victim, then writes the row
//   back and loads the result register before it pops the next item from the queue.
//   LRU age is kept as a per-line access stamp against a record counter.
// Reset: synchronous, active low; clears all valid bits, totals and the queue and
//   restores set_bits 1, block_bits 4, ways 1. No clearing pass is needed.
// Stall: a held result waits in the output register; the queue keeps accepting
//   until full, then o_in_ready drops.
module lru_set_associative_cache_sim (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [lsac_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [lsac_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic [1:0]                      i_op,
    input  logic [lsac_pkg::ADDR_W-1:0]     i_address,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic [1:0]                      o_hits,
    output logic [1:0]                      o_misses,
    output logic                            o_evictions,
    output logic [lsac_pkg::TOTAL_W-1:0]    o_total_hits,
    output logic [lsac_pkg::TOTAL_W-1:0]    o_total_misses,
    output logic [lsac_pkg::TOTAL_W-1:0]    o_total_evictions
);
    import lsac_pkg::*;

    t_job    front_job;
    t_job    queue_job;
    logic    queue_valid;
    logic    back_pop;
    t_result result;

    lsac_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_op       (t_op'(i_op)),
        .i_address  (i_address),
        .o_job      (front_job)
    );

    lsac_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (i_in_valid),
        .i_push_job   (front_job),
        .o_push_ready (o_in_ready),
        .i_pop        (back_pop),
        .o_pop_valid  (queue_valid),
        .o_pop_job    (queue_job)
    );

    lsac_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (queue_valid),
        .i_job       (queue_job),
        .o_pop       (back_pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_result    (result)
    );

    assign o_hits            = result.hits;
    assign o_misses          = result.misses;
    assign o_evictions       = result.evictions;
    assign o_total_hits      = result.total_hits;
    assign o_total_misses    = result.total_misses;
    assign o_total_evictions = result.total_evictions;

    a_evict_is_miss: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_evictions |-> o_misses == 2'd1)
        else $error("eviction reported without a miss");

    a_single_miss: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_misses == 2'd0 || o_misses == 2'd1))
        else $error("more than one miss in one item");

    a_evict_le_miss: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_total_evictions <= o_total_misses)
        else $error("eviction total above miss total");

    a_hits_monotonic: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_ready |=> !o_out_valid || o_total_hits >= $past(o_total_hits))
        else $error("hit total went down");

endmodule

[tb/sv/lsac_tb_pkg.sv]
// Scoreboard class for the LRU set-associative cache testbench: tag store
// predictor, expected result queue and result comparison. Depends on lsac_pkg.
package lsac_tb_pkg;

    import lsac_pkg::*;

    localparam int NUM_LINES    = NUM_SETS * MAX_WAYS;
    localparam int REPORT_LIMIT = 10;

    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    typedef enum logic [1:0] {
        LOOKUP_HIT,
        LOOKUP_FILL,
        LOOKUP_EVICT
    } t_lookup;

    class lru_tag_model;
        bit                 line_valid [NUM_LINES];
        bit [31:0]          line_tag   [NUM_LINES];
        bit [AGE_W-1:0]     line_age   [NUM_LINES];
        bit [TOTAL_W-1:0]   hit_total;
        bit [TOTAL_W-1:0]   miss_total;
        bit [TOTAL_W-1:0]   evict_total;
        bit [SB_W-1:0]      set_bits;
        bit [BB_W-1:0]      block_bits;
        bit [WAYS_W-1:0]    ways;
        t_result            expected_results [$];
        int unsigned        items_seen;
        int unsigned        results_seen;
        int unsigned        mismatches;

        function new();
            foreach (line_valid[k]) begin
                line_valid[k] = 1'b0;
                line_tag[k]   = '0;
                line_age[k]   = '0;
            end
            hit_total    = '0;
            miss_total   = '0;
            evict_total  = '0;
            set_bits     = RST_SET_BITS;
            block_bits   = RST_BLOCK_BITS;
            ways         = RST_WAYS;
            items_seen   = 0;
            results_seen = 0;
            mismatches   = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_SET_BITS:   set_bits   = data[SB_W-1:0];
                CFG_BLOCK_BITS: block_bits = data[BB_W-1:0];
                CFG_WAYS:       ways       = data[WAYS_W-1:0];
                default: ;
            endcase
        endfunction

        function int unsigned eff_set_bits();
            if (set_bits == 0) return 1;
            if (set_bits > MAX_SET_BITS) return MAX_SET_BITS;
            return set_bits;
        endfunction

        function int unsigned eff_block_bits();
            return (block_bits == 0) ? 1 : block_bits;
        endfunction

        function int unsigned eff_ways();
            if (ways == 0) return 1;
            if (ways > MAX_WAYS) return MAX_WAYS;
            return ways;
        endfunction

        function bit [31:0] sat_inc(bit [31:0] v);
            return (v == '1) ? v : v + 1;
        endfunction

        function t_lookup lookup(bit [ADDR_W-1:0] addr);
            int unsigned sb;
            int unsigned bb;
            int unsigned nw;
            int unsigned set_idx;
            int unsigned base;
            int unsigned victim;
            bit [31:0]   tag;
            bit [31:0]   oldest;
            sb      = eff_set_bits();
            bb      = eff_block_bits();
            nw      = eff_ways();
            set_idx = (bb >= 32) ? 0 : ((addr >> bb) & ((1 << sb) - 1));
            tag     = (sb + bb >= 32) ? 0 : (addr >> (sb + bb));
            base    = set_idx * MAX_WAYS;
            victim  = base;
            oldest  = '0;
            for (int w = 0; w < nw; w++) begin
                if (line_valid[base + w] && line_tag[base + w] == tag) begin
                    line_age[base + w] = '0;
                    return LOOKUP_HIT;
                end
            end
            for (int w = 0; w < nw; w++) begin
                if (!line_valid[base + w]) begin
                    line_valid[base + w] = 1'b1;
                    line_tag[base + w]   = tag;
                    line_age[base + w]   = '0;
                    return LOOKUP_FILL;
                end
            end
            for (int w = 0; w < nw; w++) begin
                if (w == 0 || line_age[base + w] > oldest) begin
                    oldest = line_age[base + w];
                    victim = base + w;
                end
            end
            line_tag[victim] = tag;
            line_age[victim] = '0;
            return LOOKUP_EVICT;
        endfunction

        function void note_item(logic [1:0] op_bits, logic [ADDR_W-1:0] addr);
            t_op         op;
            t_lookup     outcome;
            t_result     exp;
            int unsigned accesses;
            op  = t_op'(op_bits);
            exp = '0;
            accesses = (op == OP_MODIFY) ? 2 : ((op == OP_OTHER) ? 0 : 1);
            for (int i = 0; i < accesses; i++) begin
                outcome = lookup(addr);
                if (outcome == LOOKUP_HIT) begin
                    exp.hits  = exp.hits + 1;
                    hit_total = sat_inc(hit_total);
                end else begin
                    exp.misses = exp.misses + 1;
                    miss_total = sat_inc(miss_total);
                    if (outcome == LOOKUP_EVICT) begin
                        exp.evictions = 1'b1;
                        evict_total   = sat_inc(evict_total);
                    end
                end
            end
            foreach (line_valid[k])
                if (line_valid[k]) line_age[k] = sat_inc(line_age[k]);
            exp.total_hits      = hit_total;
            exp.total_misses    = miss_total;
            exp.total_evictions = evict_total;
            expected_results.push_back(exp);
            items_seen++;
        endfunction

        function void check_result(t_result got);
            t_result exp;
            bit      bad;
            results_seen++;
            if (expected_results.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("result %0d arrived with no item pending", results_seen);
                return;
            end
            exp = expected_results.pop_front();
            bad = (got.hits !== exp.hits) || (got.misses !== exp.misses)
                || (got.evictions !== exp.evictions) || (got.total_hits !== exp.total_hits)
                || (got.total_misses !== exp.total_misses)
                || (got.total_evictions !== exp.total_evictions);
            if (bad) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display({"result %0d mismatch: expected h=%0d m=%0d e=%0d th=%0d tm=%0d ",
                              "te=%0d, got h=%0d m=%0d e=%0d th=%0d tm=%0d te=%0d"},
                             results_seen, exp.hits, exp.misses, exp.evictions,
                             exp.total_hits, exp.total_misses, exp.total_evictions,
                             got.hits, got.misses, got.evictions,
                             got.total_hits, got.total_misses, got.total_evictions);
            end
        endfunction
    endclass

endpackage

[tb/sv/lru_set_associative_cache_sim_tb.sv]
// Top testbench for lru_set_associative_cache_sim: directed and random trace
// items over many cache settings, random idling on both channels, result check.
// Depends on lsac_pkg and lsac_tb_pkg.
module lru_set_associative_cache_sim_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import lsac_pkg::*;
    import lsac_tb_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 8;
    localparam int PHASE_ITEMS  = 60;
    localparam int NUM_PHASES   = 14;
    localparam int FIXED_PHASES = 12;
    localparam int IDLE_PCT     = 7;
    localparam int HOLD_AT      = 300;
    localparam int HOLD_CYCLES  = 120;
    localparam int QUIET_FROM   = 450;
    localparam int QUIET_TO     = 600;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   i_cfg_we;
    logic [CFG_IDX_W-1:0]   i_cfg_idx;
    logic [CFG_DATA_W-1:0]  i_cfg_data;
    logic                   i_in_valid;
    logic                   o_in_ready;
    logic [1:0]             i_op;
    logic [ADDR_W-1:0]      i_address;
    logic                   o_out_valid;
    logic                   i_out_ready;
    logic [1:0]             o_hits;
    logic [1:0]             o_misses;
    logic                   o_evictions;
    logic [TOTAL_W-1:0]     o_total_hits;
    logic [TOTAL_W-1:0]     o_total_misses;
    logic [TOTAL_W-1:0]     o_total_evictions;

    lru_tag_model cache_model = new();

    int unsigned send_idle_pct = IDLE_PCT;
    int unsigned hold_left     = 0;
    bit          hold_done     = 1'b0;
    int unsigned cycle_count   = 0;
    int unsigned settings_applied = 0;

    lru_set_associative_cache_sim u_dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_idx         (i_cfg_idx),
        .i_cfg_data        (i_cfg_data),
        .i_in_valid        (i_in_valid),
        .o_in_ready        (o_in_ready),
        .i_op              (i_op),
        .i_address         (i_address),
        .o_out_valid       (o_out_valid),
        .i_out_ready       (i_out_ready),
        .o_hits            (o_hits),
        .o_misses          (o_misses),
        .o_evictions       (o_evictions),
        .o_total_hits      (o_total_hits),
        .o_total_misses    (o_total_misses),
        .o_total_evictions (o_total_evictions)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("lru_set_associative_cache_sim verification failed");
        $finish;
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_cfg_we) cache_model.write_reg(i_cfg_idx, i_cfg_data);
            if (i_in_valid && o_in_ready) cache_model.note_item(i_op, i_address);
            if (o_out_valid && i_out_ready)
                cache_model.check_result(t_result'({o_hits, o_misses, o_evictions,
                    o_total_hits, o_total_misses, o_total_evictions}));
        end
    end

    // receiver: random stalls, one long hold-off while items keep coming, one quiet stretch
    initial begin
        i_out_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_left != 0) begin
                hold_left--;
                i_out_ready <= 1'b0;
            end else if (!hold_done && i_in_valid && cache_model.results_seen >= HOLD_AT) begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES - 1;
                i_out_ready <= 1'b0;
            end else if (cache_model.results_seen >= QUIET_FROM
                         && cache_model.results_seen < QUIET_TO) begin
                i_out_ready <= 1'b1;
            end else begin
                i_out_ready <= ($urandom_range(0, 99) >= IDLE_PCT);
            end
        end
    end

    function automatic t_op pick_op();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 35) return OP_LOAD;
        if (roll < 65) return OP_STORE;
        if (roll < 88) return OP_MODIFY;
        return OP_OTHER;
    endfunction

    // mostly a few tags over a few sets so that hits and evictions are common
    function automatic logic [ADDR_W-1:0] pick_address();
        int unsigned sb;
        int unsigned bb;
        int unsigned roll;
        logic [63:0] tag;
        logic [63:0] set_idx;
        logic [63:0] offset;
        logic [63:0] addr;
        sb   = cache_model.eff_set_bits();
        bb   = cache_model.eff_block_bits();
        roll = $urandom_range(0, 99);
        if (roll < 10) return $urandom();
        tag     = (roll < 85) ? 64'($urandom_range(0, 5)) : 64'($urandom());
        set_idx = ($urandom_range(0, 1) == 0) ? 64'($urandom_range(0, 1))
                                              : 64'($urandom_range(0, (1 << sb) - 1));
        offset  = 64'($urandom()) & ((64'd1 << bb) - 1);
        addr    = (tag << (sb + bb)) | (set_idx << bb) | offset;
        return addr[ADDR_W-1:0];
    endfunction

    task automatic send_item(input t_op op, input logic [ADDR_W-1:0] addr);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_op       <= op;
        i_address  <= addr;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic apply_settings(input logic [SB_W-1:0] sb, input logic [BB_W-1:0] bb,
                                  input logic [WAYS_W-1:0] nw);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_SET_BITS;
        i_cfg_data <= {2'($urandom_range(0, 3)), sb};
        @(negedge i_clk);
        i_cfg_idx  <= CFG_BLOCK_BITS;
        i_cfg_data <= bb;
        @(negedge i_clk);
        i_cfg_idx  <= CFG_WAYS;
        i_cfg_data <= {2'($urandom_range(0, 3)), nw};
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        @(negedge i_clk);
        settings_applied++;
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        while (cache_model.expected_results.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    initial begin
        logic [SB_W-1:0]   ph_sb [FIXED_PHASES] = '{1, 4, 0, 7, 4, 2, 3, 5, 6, 1, 4, 2};
        logic [BB_W-1:0]   ph_bb [FIXED_PHASES] = '{4, 1, 0, 31, 28, 5, 16, 3, 12, 1, 4, 8};
        logic [WAYS_W-1:0] ph_nw [FIXED_PHASES] = '{1, 4, 0, 7, 4, 2, 3, 4, 5, 2, 1, 4};

        i_rst_n    = 1'b0;
        i_cfg_we   = 1'b0;
        i_cfg_idx  = CFG_SET_BITS;
        i_cfg_data = '0;
        i_in_valid = 1'b0;
        i_op       = OP_LOAD;
        i_address  = '0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // write to an unmapped index must change nothing
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_UNUSED;
        i_cfg_data <= 5'($urandom());
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        @(negedge i_clk);

        // reset settings: two sets, one way
        send_item(OP_LOAD,   32'h0000_0000);
        send_item(OP_LOAD,   32'h0000_0008);
        send_item(OP_STORE,  32'h0000_0010);
        send_item(OP_MODIFY, 32'h0000_0020);
        send_item(OP_OTHER,  32'hFFFF_FFFF);
        send_item(OP_LOAD,   32'hFFFF_FFFF);
        send_item(OP_STORE,  32'hFFFF_FFFF);
        send_item(OP_MODIFY, 32'h0000_0000);
        send_item(OP_OTHER,  32'h0000_0000);
        drain();

        // widest geometry: fill set 0, then evict the least recently used way
        apply_settings(3'd4, 5'd1, 3'd4);
        send_item(OP_LOAD,   32'h0000_0000);
        send_item(OP_LOAD,   32'h0000_0020);
        send_item(OP_STORE,  32'h0000_0040);
        send_item(OP_LOAD,   32'h0000_0060);
        send_item(OP_LOAD,   32'h0000_0080);
        send_item(OP_LOAD,   32'h0000_0020);
        send_item(OP_LOAD,   32'h0000_0000);
        send_item(OP_MODIFY, 32'hFFFF_FFFE);
        send_item(OP_OTHER,  32'h5555_5555);
        send_item(OP_LOAD,   32'hAAAA_AAAA);
        send_item(OP_STORE,  32'h0000_001F);
        drain();

        for (int p = 0; p < NUM_PHASES; p++) begin
            if (p < FIXED_PHASES)
                apply_settings(ph_sb[p], ph_bb[p], ph_nw[p]);
            else
                apply_settings(3'($urandom_range(0, 7)), 5'($urandom_range(0, 31)),
                               3'($urandom_range(0, 7)));
            send_idle_pct = (p == 8) ? 0 : IDLE_PCT;
            repeat (PHASE_ITEMS) send_item(pick_op(), pick_address());
            drain();
        end

        $display("covered %0d trace items over %0d cache settings in %0d cycles",
                 cache_model.items_seen, settings_applied + 1, cycle_count);
        $display("model totals: %0d hits, %0d misses, %0d evictions, %0d mismatches",
                 cache_model.hit_total, cache_model.miss_total, cache_model.evict_total,
                 cache_model.mismatches);
        if (cache_model.mismatches == 0 && cache_model.expected_results.size() == 0)
            $display("lru_set_associative_cache_sim verification clean");
        else
            $display("lru_set_associative_cache_sim verification failed");
        $finish;
    end

endmodule
